@@ rtl/acrv_pkg.sv @@
package acrv_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int LINE_W    = 24;
  localparam int OUT_W     = 26;
  localparam int FRAC      = 16;
  // signal path width in Q16, covers the worst case growth through three allpasses
  localparam int XW        = 48;
  // exact product of gain and a signal value
  localparam int ACC_W     = 62;
  localparam int MUL_W     = GAIN_W + 1 + LINE_W;
  // low part of a split multiplication operand
  localparam int LO_W      = LINE_W - 1;

  localparam int AP_LEN_C  = 43;
  localparam int NUM_AP    = 3;
  localparam int NUM_COMB  = 4;
  localparam int NUM_SEC   = NUM_AP + NUM_COMB;
  localparam int SEC_W     = 3;
  localparam int CIDX_W    = 2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_AP_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMB_A  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMB_B  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COMB_C  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COMB_D  = 3'd4;

  localparam logic [GAIN_W-1:0] AP_GAIN_RST = 16'd45875;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_D,
    OP_T,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_ACC,
    OP_TR,
    OP_AP_OUT,
    OP_C_SUM,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [GAIN_W-1:0] gain;
  } ctl_t;

endpackage

@@ rtl/acrv_ram.sv @@
module acrv_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/acrv_dpath.sv @@
module acrv_dpath (
  input  logic                                   clk_i,
  input  acrv_pkg::ctl_t                         ctl_i,
  input  logic signed [acrv_pkg::SAMPLE_W-1:0]   left_i,
  input  logic signed [acrv_pkg::SAMPLE_W-1:0]   right_i,
  input  logic signed [acrv_pkg::LINE_W-1:0]     rdata_i,
  output logic        [acrv_pkg::LINE_W-1:0]     line_wdata_o,
  output logic signed [acrv_pkg::OUT_W-1:0]      reverb_o
);
  import acrv_pkg::*;

  logic signed [XW-1:0]     x_q, t_q, sum_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [MUL_W-1:0]  mul_q;
  logic signed [LINE_W-1:0] d_q;
  logic signed [OUT_W-1:0]  out_q;

  logic signed [SAMPLE_W:0] mono;
  logic signed [LINE_W-1:0] mul_b;
  logic signed [MUL_W-1:0]  prod;
  logic signed [XW-1:0]     t_int, sum_int;
  logic                     t_ovf, sum_ovf;

  assign mono = {left_i[SAMPLE_W-1], left_i} + {right_i[SAMPLE_W-1], right_i};

  // the one multiplier, gain times a 24-bit operand
  always_comb begin
    case (ctl_i.op)
      OP_MUL_LO: mul_b = {1'b0, t_q[LO_W-1:0]};
      OP_MUL_HI: mul_b = t_q[LO_W+LINE_W-1:LO_W];
      default:   mul_b = rdata_i;
    endcase
  end

  assign prod = $signed({1'b0, ctl_i.gain}) * mul_b;

  // truncation toward zero: bias negative values before the shift
  assign t_int = (t_q + $signed({{(XW-FRAC){1'b0}}, {FRAC{t_q[XW-1]}}})) >>> FRAC;
  assign sum_int = (sum_q + $signed({{(XW-FRAC){1'b0}}, {FRAC{sum_q[XW-1]}}})) >>> FRAC;

  assign t_ovf = !((&t_int[XW-1:LINE_W-1]) || !(|t_int[XW-1:LINE_W-1]));
  assign sum_ovf = !((&sum_int[XW-1:OUT_W-1]) || !(|sum_int[XW-1:OUT_W-1]));

  always_comb begin
    if (t_ovf) begin
      line_wdata_o = t_int[XW-1] ? {1'b1, {(LINE_W-1){1'b0}}} : {1'b0, {(LINE_W-1){1'b1}}};
    end else begin
      line_wdata_o = t_int[LINE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_LOAD: begin
        x_q   <= XW'(mono) <<< FRAC;
        sum_q <= '0;
      end
      OP_MUL_D: begin
        mul_q <= prod;
        d_q   <= rdata_i;
      end
      OP_T:      t_q   <= x_q + XW'(mul_q);
      OP_MUL_LO: mul_q <= prod;
      OP_MUL_HI: begin
        acc_q <= ACC_W'(mul_q);
        mul_q <= prod;
      end
      OP_ACC:    acc_q <= acc_q + (ACC_W'(mul_q) <<< LO_W);
      OP_TR: begin
        acc_q <= (acc_q + $signed({{(ACC_W-FRAC){1'b0}}, {FRAC{acc_q[ACC_W-1]}}})) >>> FRAC;
      end
      OP_AP_OUT: x_q   <= (XW'(d_q) <<< FRAC) - XW'(acc_q);
      OP_C_SUM:  sum_q <= sum_q + t_q;
      OP_FIN: begin
        if (sum_ovf) begin
          out_q <= sum_int[XW-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
          out_q <= sum_int[OUT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign reverb_o = out_q;

endmodule

@@ rtl/allpass_comb_reverb.sv @@
// Mono reverberator: three allpass sections in series feeding four parallel
// feedback combs, every delay line held in one shared single-write RAM.
// Input channel: in_valid_i / in_stall_o with left_sample_i and right_sample_i.
// Output channel: out_valid_o / out_stall_i with reverb_sample_o.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 allpass gain, 1..4 comb gains, other indexes ignored); write while idle.
// Each item is worked in sequence on one reused multiplier, three products
// per allpass and one per comb, plus a final output step; in_stall_o is high
// while the item is at work.
// After reset a clearing pass zeroes the delay RAM, one entry per cycle,
// covering all lines together (8313 entries at the default lengths);
// in_stall_o stays high until it ends.
// A finished result waits in the output register while out_stall_i is high;
// the next item is accepted meanwhile and holds its result back until the
// register is free.
module allpass_comb_reverb #(
  parameter int COMB_LEN_A    = 1777,
  parameter int COMB_LEN_B    = 1847,
  parameter int COMB_LEN_C    = 1993,
  parameter int COMB_LEN_D    = 2137,
  parameter int ALLPASS_LEN_A = 389,
  parameter int ALLPASS_LEN_B = 127
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [acrv_pkg::SAMPLE_W-1:0]  left_sample_i,
  input  logic signed [acrv_pkg::SAMPLE_W-1:0]  right_sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [acrv_pkg::OUT_W-1:0]     reverb_sample_o,
  input  logic                                  cfg_we_i,
  input  logic [acrv_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [acrv_pkg::GAIN_W-1:0]           cfg_wdata_i
);
  import acrv_pkg::*;

  localparam int Len [NUM_SEC] = '{ALLPASS_LEN_A, ALLPASS_LEN_B, AP_LEN_C,
                                   COMB_LEN_A, COMB_LEN_B, COMB_LEN_C, COMB_LEN_D};
  localparam int Base [NUM_SEC] = '{
    0,
    ALLPASS_LEN_A,
    ALLPASS_LEN_A + ALLPASS_LEN_B,
    ALLPASS_LEN_A + ALLPASS_LEN_B + AP_LEN_C,
    ALLPASS_LEN_A + ALLPASS_LEN_B + AP_LEN_C + COMB_LEN_A,
    ALLPASS_LEN_A + ALLPASS_LEN_B + AP_LEN_C + COMB_LEN_A + COMB_LEN_B,
    ALLPASS_LEN_A + ALLPASS_LEN_B + AP_LEN_C + COMB_LEN_A + COMB_LEN_B + COMB_LEN_C};
  localparam int Total = Base[NUM_SEC-1] + COMB_LEN_D;
  localparam int AddrW = $clog2(Total);
  localparam int MaxAp = (ALLPASS_LEN_A > ALLPASS_LEN_B) ?
                         ((ALLPASS_LEN_A > AP_LEN_C) ? ALLPASS_LEN_A : AP_LEN_C) :
                         ((ALLPASS_LEN_B > AP_LEN_C) ? ALLPASS_LEN_B : AP_LEN_C);
  localparam int MaxAb = (COMB_LEN_A > COMB_LEN_B) ? COMB_LEN_A : COMB_LEN_B;
  localparam int MaxCd = (COMB_LEN_C > COMB_LEN_D) ? COMB_LEN_C : COMB_LEN_D;
  localparam int MaxCb = (MaxAb > MaxCd) ? MaxAb : MaxCd;
  localparam int MaxLen = (MaxAp > MaxCb) ? MaxAp : MaxCb;
  localparam int PosW = $clog2(MaxLen);

  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_AP_MUL = 4'd2;
  localparam logic [3:0] ST_AP_T   = 4'd3;
  localparam logic [3:0] ST_AP_WR  = 4'd4;
  localparam logic [3:0] ST_AP_MHI = 4'd5;
  localparam logic [3:0] ST_AP_ACC = 4'd6;
  localparam logic [3:0] ST_AP_TR  = 4'd7;
  localparam logic [3:0] ST_AP_OUT = 4'd8;
  localparam logic [3:0] ST_C_MUL  = 4'd9;
  localparam logic [3:0] ST_C_ADD  = 4'd10;
  localparam logic [3:0] ST_C_WR   = 4'd11;
  localparam logic [3:0] ST_FIN    = 4'd12;

  logic [3:0]        state_q, state_d;
  logic [SEC_W-1:0]  sec_q, sec_d, rd_sec;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [AddrW-1:0]  cur_addr_q, raddr, waddr;
  logic [PosW-1:0]   pos_q [NUM_SEC];
  logic [PosW-1:0]   pos_rd, pos_nxt;
  logic              out_valid_q, out_valid_d;
  logic              rd_issue, line_we, ram_we;
  logic [GAIN_W-1:0] ap_gain_q;
  logic [GAIN_W-1:0] comb_gain_q [NUM_COMB];
  logic [CIDX_W-1:0] cidx;
  ctl_t              ctl;
  logic [LINE_W-1:0] ram_rdata, line_wdata, ram_wdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ap_gain_q <= AP_GAIN_RST;
      for (int k = 0; k < NUM_COMB; k++) begin
        comb_gain_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_AP_GAIN: ap_gain_q      <= cfg_wdata_i;
        CFG_COMB_A:  comb_gain_q[0] <= cfg_wdata_i;
        CFG_COMB_B:  comb_gain_q[1] <= cfg_wdata_i;
        CFG_COMB_C:  comb_gain_q[2] <= cfg_wdata_i;
        CFG_COMB_D:  comb_gain_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cidx = CIDX_W'(sec_q - SEC_W'(NUM_AP));

  // next line to read: first allpass on a transfer, else the following section
  assign rd_sec = (state_q == ST_IDLE || sec_q == SEC_W'(NUM_SEC - 1)) ? '0 :
                  sec_q + SEC_W'(1);
  assign pos_rd = pos_q[rd_sec];
  assign pos_nxt = (pos_rd == PosW'(Len[rd_sec] - 1)) ? '0 : pos_rd + PosW'(1);
  assign raddr = AddrW'(Base[rd_sec]) + AddrW'(pos_rd);

  always_comb begin
    state_d     = state_q;
    sec_d       = sec_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_issue    = 1'b0;
    line_we     = 1'b0;
    ctl.op      = OP_NONE;
    ctl.gain    = (sec_q < SEC_W'(NUM_AP)) ? ap_gain_q : comb_gain_q[cidx];
    unique case (state_q)
      ST_CLR: begin
        if (clr_q == AddrW'(Total - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AddrW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl.op   = OP_LOAD;
          rd_issue = 1'b1;
          sec_d    = '0;
          state_d  = ST_AP_MUL;
        end
      end
      ST_AP_MUL: begin
        ctl.op  = OP_MUL_D;
        state_d = ST_AP_T;
      end
      ST_AP_T: begin
        ctl.op  = OP_T;
        state_d = ST_AP_WR;
      end
      ST_AP_WR: begin
        ctl.op  = OP_MUL_LO;
        line_we = 1'b1;
        state_d = ST_AP_MHI;
      end
      ST_AP_MHI: begin
        ctl.op  = OP_MUL_HI;
        state_d = ST_AP_ACC;
      end
      ST_AP_ACC: begin
        ctl.op  = OP_ACC;
        state_d = ST_AP_TR;
      end
      ST_AP_TR: begin
        ctl.op  = OP_TR;
        state_d = ST_AP_OUT;
      end
      ST_AP_OUT: begin
        ctl.op   = OP_AP_OUT;
        rd_issue = 1'b1;
        sec_d    = rd_sec;
        state_d  = (sec_q == SEC_W'(NUM_AP - 1)) ? ST_C_MUL : ST_AP_MUL;
      end
      ST_C_MUL: begin
        ctl.op  = OP_MUL_D;
        state_d = ST_C_ADD;
      end
      ST_C_ADD: begin
        ctl.op  = OP_T;
        state_d = ST_C_WR;
      end
      ST_C_WR: begin
        ctl.op  = OP_C_SUM;
        line_we = 1'b1;
        if (sec_q == SEC_W'(NUM_SEC - 1)) begin
          state_d = ST_FIN;
        end else begin
          rd_issue = 1'b1;
          sec_d    = rd_sec;
          state_d  = ST_C_MUL;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          ctl.op      = OP_FIN;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      sec_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NUM_SEC; k++) begin
        pos_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      sec_q       <= sec_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (rd_issue) begin
        pos_q[rd_sec] <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      cur_addr_q <= raddr;
    end
  end

  assign ram_we    = line_we || (state_q == ST_CLR);
  assign waddr     = (state_q == ST_CLR) ? clr_q : cur_addr_q;
  assign ram_wdata = (state_q == ST_CLR) ? '0 : line_wdata;

  acrv_ram #(
    .Width (LINE_W),
    .Depth (Total)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  acrv_dpath u_dpath (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .left_i       (left_sample_i),
    .right_i      (right_sample_i),
    .rdata_i      (ram_rdata),
    .line_wdata_o (line_wdata),
    .reverb_o     (reverb_sample_o)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (waddr < AddrW'(Total)))
    else $error("delay ram write beyond its depth");

  a_raddr_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_issue |-> (pos_rd < PosW'(Len[rd_sec])))
    else $error("ring position beyond its line");

  a_fin_sec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> (sec_q == SEC_W'(NUM_SEC - 1)))
    else $error("result finished before the last comb");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && out_stall_i) |=> (state_q == ST_FIN))
    else $error("pending result overwritten");
`endif

endmodule
